/* src/byte_stream_tokenizer_core_defines.svh */
// Assertion macros for the tokenizer RTL.
`ifndef BYTE_STREAM_TOKENIZER_CORE_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_CORE_DEFINES_SVH

// Check a property on every rising clk edge outside reset.
`define BSTC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer assertion failed");

// Check that a condition never holds on a rising clk edge outside reset.
`define BSTC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tokenizer forbidden condition seen");

`endif

/* src/bst_pkg.sv */
// Package: token kinds, lexer modes, character codes, event types and helpers.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    // Token kinds
    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_STRING = 4'd1;
    localparam logic [3:0] KIND_LPAREN = 4'd2;
    localparam logic [3:0] KIND_RPAREN = 4'd3;
    localparam logic [3:0] KIND_LBRACE = 4'd4;
    localparam logic [3:0] KIND_RBRACE = 4'd5;
    localparam logic [3:0] KIND_LBRACK = 4'd6;
    localparam logic [3:0] KIND_RBRACK = 4'd7;
    localparam logic [3:0] KIND_HYPHEN = 4'd8;
    localparam logic [3:0] KIND_COMMA  = 4'd9;
    localparam logic [3:0] KIND_COLON  = 4'd10;
    localparam logic [3:0] KIND_EOF    = 4'd11;

    // Lexer modes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_SKIP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SLASH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STR     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ESC     = 3'd5;

    // Character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    // Event bookkeeping
    localparam int MAX_EVENTS = 3;
    localparam int EV_CNT_W   = $clog2(MAX_EVENTS + 1);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] content_byte;
        logic       content_valid;
        logic       token_begin;
        logic       token_end;
        logic       token_discard;
        logic       last_result;
    } event_t;

    typedef struct packed {
        event_t [MAX_EVENTS-1:0] ev;
        logic [EV_CNT_W-1:0]     count;
        logic [MODE_W-1:0]       mode_next;
    } lex_result_t;

    typedef struct packed {
        logic              valid;
        event_t            ev;
        logic [MODE_W-1:0] mode;
    } fresh_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
               ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
    endfunction

    // KIND_IDENT doubles as "not a one-byte token".
    function automatic logic [3:0] single_kind(input logic [7:0] b);
        logic [3:0] k;
        case (b)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_HYPHEN: k = KIND_HYPHEN;
            CH_COMMA:  k = KIND_COMMA;
            CH_COLON:  k = KIND_COLON;
            default:   k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic event_t content_event(input logic [3:0] kind, input logic [7:0] b,
                                             input logic begin_flag);
        event_t e;
        e = '0;
        e.token_kind    = kind;
        e.content_byte  = b;
        e.content_valid = 1'b1;
        e.token_begin   = begin_flag;
        return e;
    endfunction

    function automatic event_t marker_event(input logic [3:0] kind, input logic begin_flag,
                                            input logic end_flag, input logic discard_flag);
        event_t e;
        e = '0;
        e.token_kind    = kind;
        e.token_begin   = begin_flag;
        e.token_end     = end_flag;
        e.token_discard = discard_flag;
        return e;
    endfunction

    // Handle a byte seen between tokens.
    function automatic fresh_t fresh_byte(input logic [7:0] b);
        fresh_t     f;
        logic [3:0] k;
        k = single_kind(b);
        f = '0;
        f.mode = MODE_SKIP;
        if (b == CH_SLASH) begin
            f.mode = MODE_SLASH;
        end else if (is_letter(b)) begin
            f.valid = 1'b1;
            f.ev    = content_event(KIND_IDENT, b, 1'b1);
            f.mode  = MODE_IDENT;
        end else if (b == CH_QUOTE) begin
            f.valid = 1'b1;
            f.ev    = marker_event(KIND_STRING, 1'b1, 1'b0, 1'b0);
            f.mode  = MODE_STR;
        end else if (k != KIND_IDENT) begin
            f.valid = 1'b1;
            f.ev    = marker_event(k, 1'b1, 1'b1, 1'b0);
        end
        return f;
    endfunction

endpackage

`default_nettype wire

/* src/bst_lexer.sv */
// Lexer next-state logic: one byte and the current mode in, up to three events out.
`timescale 1ns / 1ps
`default_nettype none

module bst_lexer
(
    input  wire logic [bst_pkg::MODE_W-1:0] mode,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       end_of_data,
    output bst_pkg::lex_result_t            result
);

    always_comb
    begin
        bst_pkg::event_t                 e0;
        bst_pkg::event_t                 ef;
        bst_pkg::event_t                 ee;
        logic                            e0_v;
        logic                            ef_v;
        logic                            ee_v;
        bst_pkg::fresh_t                 fr;
        logic [bst_pkg::MODE_W-1:0]      mode_t;
        logic                            open_tok;
        logic [bst_pkg::EV_CNT_W-1:0]    idx;

        fr     = bst_pkg::fresh_byte(data_byte);
        e0     = '0;
        e0_v   = 1'b0;
        ef     = fr.ev;
        ef_v   = 1'b0;
        mode_t = mode;

        if (data_byte != bst_pkg::CH_NUL)
        begin
            unique case (mode)
                bst_pkg::MODE_SLASH:
                begin
                    if (data_byte == bst_pkg::CH_SLASH)
                    begin
                        mode_t = bst_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        ef_v   = fr.valid;
                        mode_t = fr.mode;
                    end
                end
                bst_pkg::MODE_COMMENT:
                begin
                    if (data_byte == bst_pkg::CH_LF)
                    begin
                        mode_t = bst_pkg::MODE_SKIP;
                    end
                end
                bst_pkg::MODE_IDENT:
                begin
                    e0_v = 1'b1;
                    if (bst_pkg::is_letter(data_byte) ||
                        (data_byte == bst_pkg::CH_UNDERSCORE))
                    begin
                        e0 = bst_pkg::content_event(bst_pkg::KIND_IDENT, data_byte, 1'b0);
                    end
                    else
                    begin
                        // close the identifier, then treat the byte as new
                        e0     = bst_pkg::marker_event(bst_pkg::KIND_IDENT, 1'b0, 1'b1, 1'b0);
                        ef_v   = fr.valid;
                        mode_t = fr.mode;
                    end
                end
                bst_pkg::MODE_STR:
                begin
                    if (data_byte == bst_pkg::CH_QUOTE)
                    begin
                        e0_v   = 1'b1;
                        e0     = bst_pkg::marker_event(bst_pkg::KIND_STRING, 1'b0, 1'b1, 1'b0);
                        mode_t = bst_pkg::MODE_SKIP;
                    end
                    else if (data_byte == bst_pkg::CH_BACKSLASH)
                    begin
                        mode_t = bst_pkg::MODE_ESC;
                    end
                    else if (data_byte != bst_pkg::CH_LF)
                    begin
                        e0_v = 1'b1;
                        e0   = bst_pkg::content_event(bst_pkg::KIND_STRING, data_byte, 1'b0);
                    end
                end
                bst_pkg::MODE_ESC:
                begin
                    mode_t = bst_pkg::MODE_STR;
                    if (data_byte != bst_pkg::CH_LF)
                    begin
                        e0_v = 1'b1;
                        e0   = bst_pkg::content_event(bst_pkg::KIND_STRING, data_byte, 1'b0);
                    end
                end
                default:
                begin
                    ef_v   = fr.valid;
                    mode_t = fr.mode;
                end
            endcase
        end

        // end of text: cancel an open identifier or string, report EOF
        open_tok = (mode_t == bst_pkg::MODE_IDENT) || (mode_t == bst_pkg::MODE_STR) ||
                   (mode_t == bst_pkg::MODE_ESC);
        ee_v = (data_byte == bst_pkg::CH_NUL) || end_of_data;
        ee   = bst_pkg::marker_event(bst_pkg::KIND_EOF, 1'b0, 1'b1, open_tok);
        if (ee_v)
        begin
            mode_t = bst_pkg::MODE_SKIP;
        end

        // pack the events in order into the low slots
        result    = '0;
        idx       = '0;
        if (e0_v)
        begin
            result.ev[idx] = e0;
            idx            = idx + 1'b1;
        end
        if (ef_v)
        begin
            result.ev[idx] = ef;
            idx            = idx + 1'b1;
        end
        if (ee_v)
        begin
            result.ev[idx] = ee;
            idx            = idx + 1'b1;
        end
        if (idx != '0)
        begin
            result.ev[idx - 1'b1].last_result = 1'b1;
        end
        result.count     = idx;
        result.mode_next = mode_t;
    end

endmodule

`default_nettype wire

/* src/byte_stream_tokenizer_core.sv */
// Top level of the streaming byte tokenizer: mode register and event queue.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | in_valid/in_stall  | data_byte, end_of_data
//  output  | out       | out_valid/out_stall| token_kind, content_byte, content_valid,
//          |           |                    | token_begin, token_end, token_discard,
//          |           |                    | last_result
//
// One byte is lexed in the cycle it transfers; its events (zero to three) land in a
// four-entry event queue and leave one per cycle while out_stall is low, from the
// cycle after the byte at the earliest. A byte transfers whenever the queue holds at
// most one event, so bytes with at most one event stream at one per cycle while out_stall is low.
// Reset returns the lexer to skip mode and empties the queue.
// A stalled output holds its head event; the input stalls only on queue space.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_tokenizer_core_defines.svh"

module byte_stream_tokenizer_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // input byte channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,

    // token event channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      token_kind,
    output logic [7:0]      content_byte,
    output logic            content_valid,
    output logic            token_begin,
    output logic            token_end,
    output logic            token_discard,
    output logic            last_result
);

    localparam int QDEPTH     = bst_pkg::QDEPTH;
    localparam int QPTR_W     = bst_pkg::QPTR_W;
    localparam int QCNT_W     = bst_pkg::QCNT_W;
    localparam int MAX_EVENTS = bst_pkg::MAX_EVENTS;

    // Lexer state: skip, slash seen, comment, identifier, string, escape.
    logic [bst_pkg::MODE_W-1:0] mode_reg;
    logic [bst_pkg::MODE_W-1:0] mode_next;

    // Event queue
    bst_pkg::event_t   queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    bst_pkg::lex_result_t lex_res;
    bst_pkg::event_t      head;
    logic                 in_xfer;
    logic                 out_xfer;
    logic [QCNT_W-1:0]    push_cnt;

    bst_lexer u_lexer
    (
        .mode        (mode_reg),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .result      (lex_res)
    );

    // Take a byte only when the queue has room for the worst case of three events.
    assign in_stall = (count_reg > QCNT_W'(QDEPTH - MAX_EVENTS));
    assign in_xfer  = in_valid && !in_stall;

    assign out_valid = (count_reg != '0);
    assign out_xfer  = out_valid && !out_stall;

    assign push_cnt = in_xfer ? QCNT_W'(lex_res.count) : '0;

    always_comb
    begin
        mode_next   = in_xfer ? lex_res.mode_next : mode_reg;
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + (out_xfer ? QPTR_W'(1) : '0);
        count_next  = count_reg + push_cnt - (out_xfer ? QCNT_W'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bst_pkg::MODE_SKIP;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the new events in order behind the queue tail.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            if (in_xfer && (i < int'(lex_res.count)))
            begin
                queue_reg[wr_ptr_reg + QPTR_W'(i)] <= lex_res.ev[i];
            end
        end
    end

    // Drive the output from the queue head.
    assign head          = queue_reg[rd_ptr_reg];
    assign token_kind    = head.token_kind;
    assign content_byte  = head.content_byte;
    assign content_valid = head.content_valid;
    assign token_begin   = head.token_begin;
    assign token_end     = head.token_end;
    assign token_discard = head.token_discard;
    assign last_result   = head.last_result;

    // Queue never holds more than its depth.
    `BSTC_ASSERT_NEVER(a_queue_no_overflow, count_reg > QCNT_W'(QDEPTH))
    // End of text always returns the lexer to skip mode.
    `BSTC_ASSERT(a_eod_resets_mode, in_xfer && end_of_data |=> mode_reg == bst_pkg::MODE_SKIP)
    // Unused mode codes are never entered.
    `BSTC_ASSERT_NEVER(a_mode_legal, mode_reg > bst_pkg::MODE_ESC)
    // Every transferred byte that causes events marks its final event as the last one.
    `BSTC_ASSERT(a_last_marked, in_xfer && lex_res.count != '0 |-> lex_res.ev[lex_res.count - 1'b1].last_result)

endmodule

`default_nettype wire

/* tb/sv/byte_stream_tokenizer_core_test.sv */
// Self-checking testbench for the byte stream tokenizer core.
`timescale 1ns / 1ps

import bst_pkg::*;

// Tracks the lexer mode and the token events that accepted bytes must produce.
class token_event_tracker;
    logic [MODE_W-1:0] scan_mode;
    event_t            pending_events[$];
    event_t            byte_events[$];
    int                errors;

    function new();
        scan_mode = MODE_SKIP;
        errors    = 0;
    endfunction

    function bit letter(logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
    endfunction

    function bit punct_kind(logic [7:0] b, output logic [3:0] kind);
        kind = KIND_IDENT;
        case (b)
            CH_LPAREN: kind = KIND_LPAREN;
            CH_RPAREN: kind = KIND_RPAREN;
            CH_LBRACE: kind = KIND_LBRACE;
            CH_RBRACE: kind = KIND_RBRACE;
            CH_LBRACK: kind = KIND_LBRACK;
            CH_RBRACK: kind = KIND_RBRACK;
            CH_HYPHEN: kind = KIND_HYPHEN;
            CH_COMMA:  kind = KIND_COMMA;
            CH_COLON:  kind = KIND_COLON;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function void add_event(logic [3:0] kind, logic [7:0] b, bit has_byte, bit first,
                            bit done, bit dropped);
        event_t e;
        e               = '0;
        e.token_kind    = kind;
        e.content_byte  = has_byte ? b : 8'h00;
        e.content_valid = has_byte;
        e.token_begin   = first;
        e.token_end     = done;
        e.token_discard = dropped;
        byte_events.push_back(e);
    endfunction

    // Handle a byte seen between tokens.
    function void start_token(logic [7:0] b);
        logic [3:0] kind;
        scan_mode = MODE_SKIP;
        if (b == CH_SLASH)
        begin
            scan_mode = MODE_SLASH;
        end
        else if (letter(b))
        begin
            add_event(KIND_IDENT, b, 1'b1, 1'b1, 1'b0, 1'b0);
            scan_mode = MODE_IDENT;
        end
        else if (b == CH_QUOTE)
        begin
            add_event(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            scan_mode = MODE_STR;
        end
        else if (punct_kind(b, kind))
        begin
            add_event(kind, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
        end
    endfunction

    // Lex one accepted byte and queue the events it causes.
    function void lex_byte(logic [7:0] b, logic eod);
        bit open_token;
        byte_events.delete();
        if (b != CH_NUL)
        begin
            case (scan_mode)
                MODE_SLASH:
                    if (b == CH_SLASH)
                        scan_mode = MODE_COMMENT;
                    else
                        start_token(b);
                MODE_COMMENT:
                    if (b == CH_LF)
                        scan_mode = MODE_SKIP;
                MODE_IDENT:
                    if (letter(b) || b == CH_UNDERSCORE)
                    begin
                        add_event(KIND_IDENT, b, 1'b1, 1'b0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        add_event(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
                        start_token(b);
                    end
                MODE_STR:
                    if (b == CH_QUOTE)
                    begin
                        add_event(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
                        scan_mode = MODE_SKIP;
                    end
                    else if (b == CH_BACKSLASH)
                    begin
                        scan_mode = MODE_ESC;
                    end
                    else if (b != CH_LF)
                    begin
                        add_event(KIND_STRING, b, 1'b1, 1'b0, 1'b0, 1'b0);
                    end
                MODE_ESC:
                begin
                    scan_mode = MODE_STR;
                    if (b != CH_LF)
                        add_event(KIND_STRING, b, 1'b1, 1'b0, 1'b0, 1'b0);
                end
                default:
                    start_token(b);
            endcase
        end
        if (b == CH_NUL || eod)
        begin
            open_token = (scan_mode == MODE_IDENT || scan_mode == MODE_STR ||
                          scan_mode == MODE_ESC);
            add_event(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b1, open_token);
            scan_mode = MODE_SKIP;
        end
        if (byte_events.size() > 0)
            byte_events[byte_events.size() - 1].last_result = 1'b1;
        foreach (byte_events[i])
            pending_events.push_back(byte_events[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare one transferred event against the oldest expected one.
    function void match_event(event_t got);
        event_t want;
        if (pending_events.size() == 0)
        begin
            $error("unexpected token event: token_kind %0d content_byte 0x%0h",
                   got.token_kind, got.content_byte);
            errors++;
            return;
        end
        want = pending_events.pop_front();
        compare_field("token_kind", want.token_kind, got.token_kind);
        compare_field("content_byte", want.content_byte, got.content_byte);
        compare_field("content_valid", want.content_valid, got.content_valid);
        compare_field("token_begin", want.token_begin, got.token_begin);
        compare_field("token_end", want.token_end, got.token_end);
        compare_field("token_discard", want.token_discard, got.token_discard);
        compare_field("last_result", want.last_result, got.last_result);
    endfunction

    function int pending();
        return pending_events.size();
    endfunction
endclass

module byte_stream_tokenizer_core_test;

    localparam int RANDOM_ITEMS  = 60;   // bytes that do more than get skipped
    localparam int HOLD_CYCLES   = 80;   // long receiver hold-off
    localparam int HOLD_AFTER    = 30;   // events seen before the hold-off starts
    localparam int DRAIN_CYCLES  = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } text_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_data = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] token_kind;
    logic [7:0] content_byte;
    logic       content_valid;
    logic       token_begin;
    logic       token_end;
    logic       token_discard;
    logic       last_result;

    token_event_tracker tracker;
    text_byte_t         text_q[$];
    int                 useful_bytes = 0;
    int                 events_seen = 0;
    event_t             seen_event;

    byte_stream_tokenizer_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_data   (end_of_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .content_byte  (content_byte),
        .content_valid (content_valid),
        .token_begin   (token_begin),
        .token_end     (token_end),
        .token_discard (token_discard),
        .last_result   (last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Append one byte of text; skip-only bytes do not count toward the random total.
    function automatic void add_byte(logic [7:0] b, logic eod, bit counts);
        text_byte_t t;
        t.data = b;
        t.eod  = eod;
        text_q.push_back(t);
        if (counts)
            useful_bytes++;
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0)
            b = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
        else
            b = 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
        return b;
    endfunction

    function automatic logic [7:0] punct_char(int unsigned i);
        case (i)
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_LBRACK;
            5:       return CH_RBRACK;
            6:       return CH_HYPHEN;
            7:       return CH_COMMA;
            default: return CH_COLON;
        endcase
    endfunction

    // Bytes that can never start a token.
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h3B;
            2:       return 8'h30 + 8'($urandom_range(0, 9));
            3:       return 8'h40;
            4:       return 8'h09;
            default: return 8'h80 + 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Short directed text: every one-byte token, skip bytes, identifier and
    // string edge cases, and every way a text can end.
    task automatic build_directed();
        int unsigned i;
        for (i = 0; i < 9; i++)
            add_byte(punct_char(i), 1'b0, 1'b0);
        add_byte(8'h3B, 1'b0, 1'b0);                // semicolon is skipped
        add_byte(8'hFF, 1'b0, 1'b0);                // high byte is skipped
        add_byte(CH_SLASH, 1'b0, 1'b0);             // lone slash, then identifier
        add_byte(CH_LOWER_A, 1'b0, 1'b0);
        add_byte(CH_UNDERSCORE, 1'b0, 1'b0);
        add_byte(CH_UPPER_Z, 1'b0, 1'b0);
        add_byte(CH_QUOTE, 1'b0, 1'b0);             // ends identifier, opens string
        add_byte(CH_BACKSLASH, 1'b0, 1'b0);         // escaped quote is kept
        add_byte(CH_QUOTE, 1'b0, 1'b0);
        add_byte(CH_LF, 1'b0, 1'b0);                // newline inside string is dropped
        add_byte(CH_BACKSLASH, 1'b0, 1'b0);         // escaped newline is dropped too
        add_byte(CH_LF, 1'b0, 1'b0);
        add_byte(CH_QUOTE, 1'b0, 1'b0);             // close the string
        add_byte("q", 1'b0, 1'b0);                  // open identifier cut by a zero byte
        add_byte(CH_NUL, 1'b0, 1'b0);
        add_byte(CH_SLASH, 1'b0, 1'b0);             // comment still open at end of data
        add_byte(CH_SLASH, 1'b0, 1'b0);
        add_byte("x", 1'b1, 1'b0);
        add_byte(CH_LOWER_Z, 1'b0, 1'b0);           // ident end, bracket and eof at once
        add_byte(CH_RBRACK, 1'b1, 1'b0);
    endtask

    // Mostly well-formed token sequences with random content, plus noise and
    // texts cut short.
    task automatic build_random_texts();
        int         choice;
        int         len;
        int         j;
        logic [7:0] b;
        while (useful_bytes < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 25)
            begin
                len = $urandom_range(1, 6);
                add_byte(random_letter(), 1'b0, 1'b1);
                for (j = 1; j < len; j++)
                    add_byte(($urandom_range(0, 4) == 0) ? CH_UNDERSCORE : random_letter(),
                             1'b0, 1'b1);
            end
            else if (choice < 45)
            begin
                add_byte(CH_QUOTE, 1'b0, 1'b1);
                len = $urandom_range(0, 6);
                for (j = 0; j < len; j++)
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            add_byte(CH_BACKSLASH, 1'b0, 1'b1);
                            add_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
                        end
                        1:
                            add_byte(CH_LF, 1'b0, 1'b1);
                        default:
                        begin
                            b = 8'($urandom_range(1, 255));
                            if (b == CH_QUOTE || b == CH_BACKSLASH)
                                b = CH_UPPER_A;
                            add_byte(b, 1'b0, 1'b1);
                        end
                    endcase
                end
                // leave some strings open for the end of the text to discard
                if ($urandom_range(0, 7) != 0)
                    add_byte(CH_QUOTE, 1'b0, 1'b1);
            end
            else if (choice < 65)
            begin
                add_byte(punct_char($urandom_range(0, 8)), 1'b0, 1'b1);
            end
            else if (choice < 73)
            begin
                add_byte(CH_SLASH, 1'b0, 1'b1);
                add_byte(CH_SLASH, 1'b0, 1'b1);
                len = $urandom_range(0, 5);
                for (j = 0; j < len; j++)
                begin
                    b = 8'($urandom_range(1, 255));
                    if (b == CH_LF)
                        b = 8'h20;
                    add_byte(b, 1'b0, 1'b0);
                end
                if ($urandom_range(0, 7) != 0)
                    add_byte(CH_LF, 1'b0, 1'b1);
            end
            else if (choice < 78)
            begin
                add_byte(CH_SLASH, 1'b0, 1'b1);
            end
            else if (choice < 85)
            begin
                // end the text on its last byte or with a zero byte
                if ($urandom_range(0, 1) == 0 && text_q.size() > 0)
                begin
                    text_q[text_q.size() - 1].eod = 1'b1;
                    useful_bytes++;
                end
                else
                begin
                    add_byte(CH_NUL, 1'($urandom_range(0, 1)), 1'b1);
                end
            end
            else
            begin
                add_byte(noise_char(), 1'b0, 1'b0);
            end
        end
        text_q[text_q.size() - 1].eod = 1'b1;
    endtask

    // Offer the text in bursts of random length with idle gaps between them.
    task automatic drive_bytes();
        int k;
        int burst;
        k = 0;
        while (k < text_q.size())
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            while (burst > 0 && k < text_q.size())
            begin
                in_valid    <= 1'b1;
                data_byte   <= text_q[k].data;
                end_of_data <= text_q[k].eod;
                // hold the payload until the transfer happens
                do
                    @(posedge clk);
                while (in_stall);
                k++;
                burst--;
            end
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Stall the event channel in phases of differing density, with one long
    // hold-off so the event queue fills and the input backs up.
    task automatic drive_out_stall();
        int   style;
        int   span;
        int   c;
        bit   held;
        logic stall_now;
        held = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(4, 40);
            for (c = 0; c < span; c++)
            begin
                if (!held && events_seen >= HOLD_AFTER)
                begin
                    held = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (style)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 99) < 30);
                    2:       stall_now = ($urandom_range(0, 99) < 75);
                    default: stall_now = c[1];
                endcase
                out_stall <= stall_now;
                @(posedge clk);
            end
        end
    endtask

    // Predict on every byte transfer.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.lex_byte(data_byte, end_of_data);
    end

    // Check every event transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_event.token_kind    = token_kind;
            seen_event.content_byte  = content_byte;
            seen_event.content_valid = content_valid;
            seen_event.token_begin   = token_begin;
            seen_event.token_end     = token_end;
            seen_event.token_discard = token_discard;
            seen_event.last_result   = last_result;
            tracker.match_event(seen_event);
            events_seen++;
        end
    end

    initial
    begin
        tracker = new();
        build_directed();
        build_random_texts();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        fork
            drive_out_stall();
        join_none
        drive_bytes();
        // drain the event queue, then give late or extra events time to show
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("byte_stream_tokenizer_core: match");
        else
            $display("byte_stream_tokenizer_core: mismatch");
        $finish;
    end

    // Bound the run well beyond the slowest legal completion.
    initial
    begin
        #2000000;
        $display("byte_stream_tokenizer_core: mismatch");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/bst_pkg.sv
src/bst_lexer.sv
src/byte_stream_tokenizer_core.sv
tb/sv/byte_stream_tokenizer_core_test.sv
